// File: sv/mqf_pkg.sv
`default_nettype none

package mqf_pkg;

	// fixed field widths
	localparam int DATA_BITS     = 32;
	localparam int FILL_BITS     = 9;
	localparam int PTR_BITS      = 9;
	localparam int CMD_BITS      = 2;
	localparam int QID_BITS      = 2;
	localparam int STATUS_BITS   = 2;
	localparam int LOG2_BITS     = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 4;
	localparam int CFG_QUEUES    = 2;

	// commands
	localparam logic [CMD_BITS-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_FILL = 2'd2;

	// result status codes
	localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_BAD_QUEUE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_Q0_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_Q0_SIZE   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_Q1_ACTIVE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Q1_SIZE   = 3'd3;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [FILL_BITS-1:0]   fill;
		logic                   take_data;
	} result_t;

	typedef struct packed {
		logic    mem_wr;
		result_t res;
	} decision_t;

endpackage

`default_nettype wire

// File: sv/mqf_ram.sv
`default_nettype none

module mqf_ram #(
	parameter int WIDTH     = 32,
	parameter int DEPTH     = 512,
	parameter int ADDR_BITS = 9
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic                 we,
	input  wire logic [ADDR_BITS-1:0] addr,
	input  wire logic [WIDTH-1:0]     wdata,
	output logic      [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read, read data holds when idle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/mqf_ctrl.sv
`default_nettype none

module mqf_ctrl #(
	parameter int NUM_QUEUES = 2,
	parameter int MAX_DEPTH  = 256,
	parameter int ADDR_BITS  = 9
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [mqf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [mqf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                 accept,
	input  wire logic [mqf_pkg::CMD_BITS-1:0]         command,
	input  wire logic [mqf_pkg::QID_BITS-1:0]         queue_id,
	output mqf_pkg::decision_t                        dec,
	output logic      [ADDR_BITS-1:0]                 mem_addr
);

	localparam int PB = mqf_pkg::PTR_BITS;
	// largest usable log2 length: floor(log2(MAX_DEPTH))
	localparam int LG_MAX = $clog2(MAX_DEPTH + 1) - 1;
	localparam logic [mqf_pkg::LOG2_BITS-1:0] LG_CAP = mqf_pkg::LOG2_BITS'(LG_MAX);
	localparam logic [ADDR_BITS-1:0] BASE1 = ADDR_BITS'(MAX_DEPTH);

	logic                             active_q [mqf_pkg::CFG_QUEUES];
	logic [mqf_pkg::LOG2_BITS-1:0]    size_q   [mqf_pkg::CFG_QUEUES];
	logic [PB-1:0]                    wp_q     [NUM_QUEUES];
	logic [PB-1:0]                    rp_q     [NUM_QUEUES];

	logic                          qid_ok;
	logic                          act;
	logic [mqf_pkg::LOG2_BITS-1:0] lg;
	logic [mqf_pkg::LOG2_BITS-1:0] eff_lg;
	logic [PB-1:0]                 wp;
	logic [PB-1:0]                 rp;
	logic [PB-1:0]                 cnt;
	logic [PB-1:0]                 len;
	logic [PB-1:0]                 mask;
	logic [PB-1:0]                 ptr_sel;
	logic [7:0]                    offset;
	logic                          enq_ok;
	logic                          deq_ok;
	logic                          cfg_q;

	// current pointers of the addressed queue
	always_comb begin
		wp = '0;
		rp = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (queue_id == mqf_pkg::QID_BITS'(i)) begin
				wp = wp_q[i];
				rp = rp_q[i];
			end
		end
	end

	// queue check, length, fill and decision
	always_comb begin
		qid_ok  = ({1'b0, queue_id} < 3'(NUM_QUEUES));
		act     = active_q[queue_id[0]];
		lg      = size_q[queue_id[0]];
		eff_lg  = (lg > LG_CAP) ? LG_CAP : lg;
		len     = PB'(1) << eff_lg;
		mask    = len - PB'(1);
		cnt     = wp - rp;
		enq_ok  = qid_ok && act && (command == mqf_pkg::CMD_ENQ) && (cnt < len);
		deq_ok  = qid_ok && act && (command == mqf_pkg::CMD_DEQ) && (cnt != '0);
		ptr_sel = (command == mqf_pkg::CMD_ENQ) ? wp : rp;
		offset  = ptr_sel[7:0] & mask[7:0];
		mem_addr = (queue_id[0] ? BASE1 : '0) + ADDR_BITS'(offset);

		dec.mem_wr        = enq_ok;
		dec.res.take_data = deq_ok;
		if (!qid_ok) begin
			dec.res.status = mqf_pkg::ST_BAD_QUEUE;
			dec.res.fill   = '0;
		end else if (!act) begin
			dec.res.status = (command == mqf_pkg::CMD_ENQ || command == mqf_pkg::CMD_DEQ)
				? mqf_pkg::ST_FULL_EMPTY : mqf_pkg::ST_OK;
			dec.res.fill   = '0;
		end else begin
			dec.res.status = ((command == mqf_pkg::CMD_ENQ && !enq_ok) ||
				(command == mqf_pkg::CMD_DEQ && !deq_ok))
				? mqf_pkg::ST_FULL_EMPTY : mqf_pkg::ST_OK;
			if (enq_ok) begin
				dec.res.fill = cnt + PB'(1);
			end else if (deq_ok) begin
				dec.res.fill = cnt - PB'(1);
			end else begin
				dec.res.fill = cnt;
			end
		end
	end

	assign cfg_q = cfg_index[1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mqf_pkg::CFG_QUEUES; i++) begin
				active_q[i] <= 1'b0;
				size_q[i]   <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				mqf_pkg::REG_Q0_ACTIVE: active_q[0] <= cfg_data[0];
				mqf_pkg::REG_Q0_SIZE:   size_q[0]   <= cfg_data;
				mqf_pkg::REG_Q1_ACTIVE: active_q[1] <= cfg_data[0];
				mqf_pkg::REG_Q1_SIZE:   size_q[1]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// free-running pointers, cleared by a write to the queue's registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (cfg_we && !cfg_index[2] && (cfg_q == 1'(i))) begin
					wp_q[i] <= '0;
					rp_q[i] <= '0;
				end else if (accept && (queue_id == mqf_pkg::QID_BITS'(i))) begin
					if (enq_ok) begin
						wp_q[i] <= wp_q[i] + PB'(1);
					end
					if (deq_ok) begin
						rp_q[i] <= rp_q[i] + PB'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/multi_queue_fifo.sv
// Bank of independent circular FIFO queues sharing one element RAM. Each queue
// owns a region of MAX_DEPTH words, a power-of-two length set by its size
// register (capped at the largest power of two not above MAX_DEPTH) and 9-bit
// free-running write/read pointers. A request enqueues, dequeues or reads the
// fill count of one queue and always yields exactly one response. Requests are
// taken one per cycle while req_stall is low; each result waits in stage 1 on
// the registered read of the element RAM, then moves to the output register.
// Writing either register of a queue clears its pointers; write configuration
// only while no request is in flight. cfg_ready is always high.
`default_nettype none

module multi_queue_fifo #(
	parameter int NUM_QUEUES   = 2,
	parameter int MAX_DEPTH    = 256,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mqf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [mqf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// request channel
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic [mqf_pkg::CMD_BITS-1:0]        command,
	input  wire logic [mqf_pkg::QID_BITS-1:0]        queue_id,
	input  wire logic [mqf_pkg::DATA_BITS-1:0]       data_in,
	// response channel
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic      [mqf_pkg::STATUS_BITS-1:0]     status,
	output logic      [mqf_pkg::DATA_BITS-1:0]       data_out,
	output logic      [mqf_pkg::FILL_BITS-1:0]       fill_count
);

	localparam int DEPTH_TOTAL = NUM_QUEUES * MAX_DEPTH;
	localparam int ADDR_BITS   = (DEPTH_TOTAL > 1) ? $clog2(DEPTH_TOTAL) : 1;
	localparam int XW = (ELEMENT_BITS > mqf_pkg::DATA_BITS) ? ELEMENT_BITS
		: mqf_pkg::DATA_BITS;

	mqf_pkg::decision_t    dec;
	logic [ADDR_BITS-1:0]  mem_addr;
	logic [ELEMENT_BITS-1:0] wdata;
	logic [ELEMENT_BITS-1:0] rdata;
	logic [XW-1:0]         in_wide;
	logic [XW-1:0]         rd_wide;
	logic                  accept;
	logic                  advance;

	logic                  valid_s1;
	mqf_pkg::result_t      res_s1;

	logic                                 rsp_valid_q;
	logic [mqf_pkg::STATUS_BITS-1:0]      status_q;
	logic [mqf_pkg::DATA_BITS-1:0]        data_out_q;
	logic [mqf_pkg::FILL_BITS-1:0]        fill_count_q;

	assign cfg_ready = 1'b1;

	// handshake: stall only when both stages are full and the output is held
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	mqf_ctrl #(
		.NUM_QUEUES (NUM_QUEUES),
		.MAX_DEPTH  (MAX_DEPTH),
		.ADDR_BITS  (ADDR_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (command),
		.queue_id  (queue_id),
		.dec       (dec),
		.mem_addr  (mem_addr)
	);

	// element word width adaption
	assign in_wide = XW'(data_in);
	assign wdata   = in_wide[ELEMENT_BITS-1:0];
	assign rd_wide = XW'(rdata);

	mqf_ram #(
		.WIDTH     (ELEMENT_BITS),
		.DEPTH     (DEPTH_TOTAL),
		.ADDR_BITS (ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.en    (accept && (dec.mem_wr || dec.res.take_data)),
		.we    (accept && dec.mem_wr),
		.addr  (mem_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// stage 1: result waiting on the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= dec.res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= res_s1.status;
			fill_count_q <= res_s1.fill;
			data_out_q   <= res_s1.take_data ? rd_wide[mqf_pkg::DATA_BITS-1:0] : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign data_out   = data_out_q;
	assign fill_count = fill_count_q;

endmodule

`default_nettype wire

// File: sim/multi_queue_fifo_test.sv
module multi_queue_fifo_test;

	localparam int NUM_Q          = 2;
	localparam int MAX_DEPTH      = 256;
	localparam int MAX_LG         = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// command code with no defined operation
	localparam logic [mqf_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	// register index past the last real register
	localparam logic [mqf_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [mqf_pkg::CMD_BITS-1:0]  cmd;
		logic [mqf_pkg::QID_BITS-1:0]  qid;
		logic [mqf_pkg::DATA_BITS-1:0] data;
	} fifo_request_t;

	typedef struct packed {
		logic [mqf_pkg::STATUS_BITS-1:0] status;
		logic [mqf_pkg::DATA_BITS-1:0]   data;
		logic [mqf_pkg::FILL_BITS-1:0]   fill;
	} fifo_response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [mqf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [mqf_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic [mqf_pkg::CMD_BITS-1:0] command = '0;
	logic [mqf_pkg::QID_BITS-1:0] queue_id = '0;
	logic [mqf_pkg::DATA_BITS-1:0] data_in = '0;
	logic rsp_stall = 1'b0;
	wire cfg_ready;
	wire req_stall;
	wire rsp_valid;
	wire [mqf_pkg::STATUS_BITS-1:0] status;
	wire [mqf_pkg::DATA_BITS-1:0] data_out;
	wire [mqf_pkg::FILL_BITS-1:0] fill_count;

	// predicted queue state and configuration
	logic [mqf_pkg::DATA_BITS-1:0] fifo_mem [0:NUM_Q*MAX_DEPTH-1];
	logic [mqf_pkg::PTR_BITS-1:0] wr_ptr [0:NUM_Q-1];
	logic [mqf_pkg::PTR_BITS-1:0] rd_ptr [0:NUM_Q-1];
	logic q_active [0:NUM_Q-1];
	logic [mqf_pkg::LOG2_BITS-1:0] q_lg [0:NUM_Q-1];

	fifo_request_t pending_requests [$];
	fifo_response_t expected_responses [$];
	fifo_request_t req_now;
	fifo_response_t rsp_got;
	fifo_response_t rsp_want;

	int sent_total = 0;
	int rsp_count = 0;
	int req_accepted = 0;
	int reg_writes = 0;
	int mismatch_count = 0;
	int full_empty_hits = 0;
	int max_fill = 0;
	int req_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	bit drv_calm = 1'b0;
	bit mon_calm = 1'b0;

	multi_queue_fifo #(
		.NUM_QUEUES  (NUM_Q),
		.MAX_DEPTH   (MAX_DEPTH),
		.ELEMENT_BITS(mqf_pkg::DATA_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.queue_id  (queue_id),
		.data_in   (data_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.data_out  (data_out),
		.fill_count(fill_count)
	);

	always #5 clk = ~clk;

	// mostly short pauses, now and then a long one; none while calm
	function automatic int pick_pause(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// expected response of one accepted request, updating the queue state
	function automatic fifo_response_t compute_response(fifo_request_t req);
		fifo_response_t rsp;
		logic [mqf_pkg::PTR_BITS-1:0] held;
		int depth;
		int q;
		rsp = '0;
		q = int'(req.qid);
		if (q >= NUM_Q) begin
			rsp.status = mqf_pkg::ST_BAD_QUEUE;
		end else if (!q_active[q]) begin
			// an inactive queue looks both full and empty
			if (req.cmd == mqf_pkg::CMD_ENQ || req.cmd == mqf_pkg::CMD_DEQ)
				rsp.status = mqf_pkg::ST_FULL_EMPTY;
		end else begin
			// lengths past MAX_DEPTH fold down to MAX_DEPTH
			depth = (q_lg[q] >= MAX_LG) ? MAX_DEPTH : (1 << q_lg[q]);
			held = wr_ptr[q] - rd_ptr[q];
			case (req.cmd)
				mqf_pkg::CMD_ENQ: begin
					if (held >= depth) begin
						rsp.status = mqf_pkg::ST_FULL_EMPTY;
					end else begin
						fifo_mem[q*MAX_DEPTH + (wr_ptr[q] & (depth - 1))] = req.data;
						wr_ptr[q] = wr_ptr[q] + 1'b1;
					end
				end
				mqf_pkg::CMD_DEQ: begin
					if (held == 0) begin
						rsp.status = mqf_pkg::ST_FULL_EMPTY;
					end else begin
						rsp.data = fifo_mem[q*MAX_DEPTH + (rd_ptr[q] & (depth - 1))];
						rd_ptr[q] = rd_ptr[q] + 1'b1;
					end
				end
				default: ;
			endcase
			rsp.fill = wr_ptr[q] - rd_ptr[q];
		end
		if (rsp.status == mqf_pkg::ST_FULL_EMPTY)
			full_empty_hits++;
		if (rsp.fill > max_fill)
			max_fill = int'(rsp.fill);
		return rsp;
	endfunction

	task automatic report_mismatch(string what, fifo_response_t want, fifo_response_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: expected status %0d data %h fill %0d, got status %0d data %h fill %0d",
				$time, what, want.status, want.data, want.fill, got.status, got.data, got.fill);
	endtask

	task automatic add_request(logic [mqf_pkg::CMD_BITS-1:0] cmd,
			logic [mqf_pkg::QID_BITS-1:0] qid, logic [mqf_pkg::DATA_BITS-1:0] data);
		fifo_request_t req;
		req.cmd = cmd;
		req.qid = qid;
		req.data = data;
		pending_requests.push_back(req);
		sent_total++;
	endtask

	// single request with random queue, command and word
	task automatic add_random(int q1_share, int enq_pct);
		logic [mqf_pkg::QID_BITS-1:0] qid;
		logic [mqf_pkg::CMD_BITS-1:0] cmd;
		logic [mqf_pkg::DATA_BITS-1:0] data;
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			qid = mqf_pkg::QID_BITS'($urandom_range(NUM_Q, 3));
		else
			qid = ($urandom_range(0, 99) < q1_share) ? 2'd1 : 2'd0;
		r = $urandom_range(0, 99);
		if (r < enq_pct)
			cmd = mqf_pkg::CMD_ENQ;
		else if (r < 90)
			cmd = mqf_pkg::CMD_DEQ;
		else if (r < 97)
			cmd = mqf_pkg::CMD_FILL;
		else
			cmd = CMD_UNUSED;
		r = $urandom_range(0, 15);
		data = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
		add_request(cmd, qid, data);
	endtask

	// mix of enqueue-then-dequeue bursts and loose single requests
	task automatic run_phase(int n_items, int q1_share, int enq_pct, int burst_max);
		logic [mqf_pkg::QID_BITS-1:0] qid;
		int start;
		int n;
		start = sent_total;
		while (sent_total - start < n_items) begin
			if ($urandom_range(0, 99) < 40) begin
				qid = ($urandom_range(0, 99) < q1_share) ? 2'd1 : 2'd0;
				n = $urandom_range(1, burst_max);
				repeat (n) add_request(mqf_pkg::CMD_ENQ, qid, $urandom);
				repeat ($urandom_range(1, n + 1)) add_request(mqf_pkg::CMD_DEQ, qid, $urandom);
			end else begin
				add_random(q1_share, enq_pct);
			end
		end
		wait_idle();
	endtask

	task automatic wait_idle();
		while (rsp_count != sent_total)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write; a write to a real register clears that queue's pointers
	task automatic write_reg(logic [mqf_pkg::CFG_IDX_BITS-1:0] idx,
			logic [mqf_pkg::CFG_DATA_BITS-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			mqf_pkg::REG_Q0_ACTIVE, mqf_pkg::REG_Q1_ACTIVE: q_active[idx[1]] = val[0];
			mqf_pkg::REG_Q0_SIZE, mqf_pkg::REG_Q1_SIZE:     q_lg[idx[1]] = val;
			default: ;
		endcase
		if (idx <= mqf_pkg::REG_Q1_SIZE) begin
			wr_ptr[idx[1]] = '0;
			rd_ptr[idx[1]] = '0;
		end
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// request driver: holds a stalled transaction, else loads the next after a gap
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			expected_responses.push_back(compute_response(req_now));
			req_accepted++;
		end
		if (!req_valid || !req_stall) begin
			if (req_gap > 0 || pending_requests.size() == 0) begin
				if (req_gap > 0)
					req_gap--;
				req_valid <= 1'b0;
			end else begin
				req_now = pending_requests.pop_front();
				command <= req_now.cmd;
				queue_id <= req_now.qid;
				data_in <= req_now.data;
				req_valid <= 1'b1;
				if ($urandom_range(0, 49) == 0)
					drv_calm = !drv_calm;
				req_gap = pick_pause(drv_calm);
			end
		end
	end

	// response monitor and random back-pressure
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			rsp_got.status = status;
			rsp_got.data = data_out;
			rsp_got.fill = fill_count;
			rsp_count++;
			if (expected_responses.size() == 0) begin
				report_mismatch("response with nothing outstanding", '0, rsp_got);
			end else begin
				rsp_want = expected_responses.pop_front();
				if (rsp_got.status !== rsp_want.status || rsp_got.data !== rsp_want.data
						|| rsp_got.fill !== rsp_want.fill)
					report_mismatch("response mismatch", rsp_want, rsp_got);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			if ($urandom_range(0, 63) == 0)
				mon_calm = !mon_calm;
			stall_left = ($urandom_range(0, 3) == 0) ? pick_pause(mon_calm) : 0;
			rsp_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a transaction", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int q = 0; q < NUM_Q; q++) begin
			wr_ptr[q] = '0;
			rd_ptr[q] = '0;
			q_active[q] = 1'b0;
			q_lg[q] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both queues inactive after reset, plus bad queue numbers
		add_request(mqf_pkg::CMD_ENQ, 2'd0, 32'hFFFF_FFFF);
		add_request(mqf_pkg::CMD_DEQ, 2'd0, 32'h0);
		add_request(mqf_pkg::CMD_FILL, 2'd0, 32'h0);
		add_request(CMD_UNUSED, 2'd0, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_ENQ, 2'd2, 32'hFFFF_FFFF);
		add_request(CMD_UNUSED, 2'd3, 32'h0);
		wait_idle();

		// one-entry queue, oversized queue, spare register index
		write_reg(mqf_pkg::REG_Q0_ACTIVE, 4'd1);
		write_reg(mqf_pkg::REG_Q0_SIZE, 4'd0);
		write_reg(mqf_pkg::REG_Q1_ACTIVE, 4'd1);
		write_reg(mqf_pkg::REG_Q1_SIZE, 4'd15);
		write_reg(REG_SPARE, 4'd15);
		add_request(mqf_pkg::CMD_ENQ, 2'd0, 32'hFFFF_FFFF);
		add_request(mqf_pkg::CMD_ENQ, 2'd0, 32'h1);
		add_request(mqf_pkg::CMD_FILL, 2'd0, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd0, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd0, 32'h0);
		add_request(mqf_pkg::CMD_ENQ, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_ENQ, 2'd1, 32'hA5A5_A5A5);
		add_request(CMD_UNUSED, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd1, 32'h0);
		add_request(mqf_pkg::CMD_DEQ, 2'd3, 32'h0);
		add_request(mqf_pkg::CMD_FILL, 2'd2, 32'h0);
		wait_idle();

		// small queues, frequent full and empty
		write_reg(mqf_pkg::REG_Q0_SIZE, 4'd1);
		write_reg(mqf_pkg::REG_Q1_SIZE, 4'd3);
		run_phase(200, 50, 50, 10);

		// fill the largest queue past full, then drain part of it
		write_reg(mqf_pkg::REG_Q1_SIZE, 4'd15);
		repeat (258) add_request(mqf_pkg::CMD_ENQ, 2'd1, $urandom);
		add_request(mqf_pkg::CMD_FILL, 2'd1, 32'h0);
		run_phase(60, 70, 30, 6);

		// queue zero switched off, queue one at exactly MAX_DEPTH
		write_reg(mqf_pkg::REG_Q0_ACTIVE, 4'd0);
		write_reg(mqf_pkg::REG_Q1_SIZE, 4'd8);
		run_phase(120, 60, 55, 12);

		// queue one switched off
		write_reg(mqf_pkg::REG_Q0_ACTIVE, 4'd1);
		write_reg(mqf_pkg::REG_Q0_SIZE, 4'd8);
		write_reg(mqf_pkg::REG_Q1_ACTIVE, 4'd0);
		write_reg(REG_SPARE, 4'd0);
		run_phase(100, 40, 50, 8);

		// both active again, queue one slightly oversized
		write_reg(mqf_pkg::REG_Q1_ACTIVE, 4'd1);
		write_reg(mqf_pkg::REG_Q1_SIZE, 4'd9);
		write_reg(mqf_pkg::REG_Q0_SIZE, 4'd2);
		run_phase(110, 50, 50, 20);

		if (expected_responses.size() != 0) begin
			$display("%0d responses never arrived", expected_responses.size());
			mismatch_count += expected_responses.size();
		end
		$display("%0d requests and %0d register writes, %0d full or empty answers",
			req_accepted, reg_writes, full_empty_hits);
		$display("largest fill count %0d, %0d errors", max_fill, mismatch_count);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: multi_queue_fifo.f
sv/mqf_pkg.sv
sv/mqf_ram.sv
sv/mqf_ctrl.sv
sv/multi_queue_fifo.sv
sim/multi_queue_fifo_test.sv
